@@ src/fresnel_dielectric_reflectance_core_assert.svh @@
// ----------------------------------------------------------------------------
// fresnel dielectric reflectance core assertion macros
// short forms for clocked properties with a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_CORE_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define FDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fdr_pkg.sv @@
// ----------------------------------------------------------------------------
// fdr_pkg
// shared types and constants of the fresnel dielectric reflectance core
// ----------------------------------------------------------------------------
package fdr_pkg;

  localparam int unsigned COS_W   = 16;
  localparam int unsigned ETA_W   = 14;
  localparam int unsigned REFL_W  = 16;

  localparam logic [ETA_W-1:0]  ETA_ONE  = 14'd4096;
  localparam logic [REFL_W-1:0] ONE_Q15  = 16'd32768;
  localparam logic [31:0]       ONE_Q30  = 32'h4000_0000;

  // sideband carried through the transmitted-cosine divider and root
  typedef struct packed {
    logic             tir;
    logic [COS_W-1:0] ci;
    logic [ETA_W-1:0] n;
    logic [ETA_W-1:0] d;
  } fdr_front_t;

endpackage

@@ src/fdr_div.sv @@
// ----------------------------------------------------------------------------
// fdr_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module fdr_div #(
  parameter int unsigned NW = 58,
  parameter int unsigned DW = 28,
  parameter int unsigned QW = 31,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] qw_r   [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  genvar i;
  for (i = 0; i < QW; i++) begin : g_step
    logic          vld_src;
    logic [DW-1:0] rem_src;
    logic [QW-1:0] qw_src;
    logic [DW-1:0] den_src;
    logic [SW-1:0] side_src;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      // numerator top bits are below the divisor, so they seed the remainder
      assign vld_src  = in_vld;
      assign rem_src  = DW'(in_num[NW-1:QW]);
      assign qw_src   = in_num[QW-1:0];
      assign den_src  = in_den;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[i-1];
      assign rem_src  = rem_r[i-1];
      assign qw_src   = qw_r[i-1];
      assign den_src  = den_r[i-1];
      assign side_src = side_r[i-1];
    end

    assign trial = {rem_src, qw_src[QW-1]};
    assign ge    = (trial >= {1'b0, den_src});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
        qw_r[i]   <= {qw_src[QW-2:0], ge};
        den_r[i]  <= den_src;
        side_r[i] <= side_src;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = qw_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

@@ src/fdr_isqrt.sv @@
// ----------------------------------------------------------------------------
// fdr_isqrt
// pipelined integer square root, floor, one root bit per stage
// ----------------------------------------------------------------------------
module fdr_isqrt #(
  parameter int unsigned IW = 32,
  parameter int unsigned SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [IW-1:0]   in_val,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [IW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int unsigned NS = IW / 2;

  logic          vld_r  [NS];
  logic [IW-1:0] v_r    [NS];
  logic [IW-1:0] res_r  [NS];
  logic [SW-1:0] side_r [NS];

  genvar k;
  for (k = 0; k < NS; k++) begin : g_step
    localparam logic [IW:0] BIT = (IW+1)'(1) << (IW - 2 - 2*k);
    logic          vld_src;
    logic [IW-1:0] v_src;
    logic [IW-1:0] res_src;
    logic [SW-1:0] side_src;
    logic [IW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_src  = in_vld;
      assign v_src    = in_val;
      assign res_src  = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign v_src    = v_r[k-1];
      assign res_src  = res_r[k-1];
      assign side_src = side_r[k-1];
    end

    assign trial = {1'b0, res_src} + BIT;
    assign ge    = ({1'b0, v_src} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= ge ? IW'({1'b0, v_src} - trial) : v_src;
        res_r[k]  <= ge ? IW'({1'b0, res_src >> 1} + BIT) : (res_src >> 1);
        side_r[k] <= side_src;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_root = res_r[NS-1][NS-1:0];
  assign out_side = side_r[NS-1];

endmodule

@@ src/fresnel_dielectric_reflectance_core.sv @@
// throughput: one item per cycle; the pipeline only pauses while a result is stalled
// depth is set by two chained pipelined dividers (31 stages each) and the 16-stage root
// reset: synchronous active-low rst_n clears every stage valid bit, data is not reset
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_core
// unpolarised fresnel reflectance of a dielectric interface in fixed point
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [fdr_pkg::COS_W-1:0] in_cos_incident,
  input  logic [fdr_pkg::ETA_W-1:0]   in_refr_ratio,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fdr_pkg::REFL_W-1:0]  out_reflectance,
  output logic                        out_total_internal
);
  import fdr_pkg::*;

  // one enable for the whole pipe: it moves unless the held result is stalled
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage a: fold the side of the surface ----------------
  logic             ray_inside;
  logic [ETA_W-1:0] e_fix;
  logic [COS_W-1:0] ci_nxt;
  logic             a_vld_r;
  logic [COS_W-1:0] a_ci_r;
  logic [ETA_W-1:0] a_n_r;
  logic [ETA_W-1:0] a_d_r;

  assign ray_inside = in_cos_incident[COS_W-1];
  // zero eta is out of range, treated as the smallest step
  assign e_fix  = (in_refr_ratio == '0) ? ETA_W'(1) : in_refr_ratio;
  // negation of the most negative code gives exactly one in unsigned form
  assign ci_nxt = ray_inside ? COS_W'(-in_cos_incident) : COS_W'(in_cos_incident);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  // eta kept as exact fraction n/d, inside rays swap numerator and denominator
  always_ff @(posedge clk) begin
    if (en) begin
      a_ci_r <= ci_nxt;
      a_n_r  <= ray_inside ? ETA_ONE : e_fix;
      a_d_r  <= ray_inside ? e_fix : ETA_ONE;
    end
  end

  // ---------------- stage b: squares ----------------
  logic [31:0]      ci2;
  logic             b_vld_r;
  logic [30:0]      b_s2_r;
  logic [27:0]      b_d2_r;
  logic [27:0]      b_n2_r;
  logic [COS_W-1:0] b_ci_r;
  logic [ETA_W-1:0] b_n_r;
  logic [ETA_W-1:0] b_d_r;

  assign ci2 = 32'(a_ci_r) * 32'(a_ci_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s2_r <= 31'(ONE_Q30 - ci2);  // squared incident sine, q30
      b_d2_r <= 28'(a_d_r) * 28'(a_d_r);
      b_n2_r <= 28'(a_n_r) * 28'(a_n_r);
      b_ci_r <= a_ci_r;
      b_n_r  <= a_n_r;
      b_d_r  <= a_d_r;
    end
  end

  // ---------------- stage c: sine term scaled by d squared ----------------
  logic             c_vld_r;
  logic [58:0]      c_lhs_r;
  logic [27:0]      c_n2_r;
  logic [COS_W-1:0] c_ci_r;
  logic [ETA_W-1:0] c_n_r;
  logic [ETA_W-1:0] c_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lhs_r <= 59'(b_s2_r) * 59'(b_d2_r);
      c_n2_r  <= b_n2_r;
      c_ci_r  <= b_ci_r;
      c_n_r   <= b_n_r;
      c_d_r   <= b_d_r;
    end
  end

  // ---------------- stage d: exact total internal reflection test ----------------
  logic [58:0] rhs;
  logic        tir_nxt;
  logic        d_vld_r;
  logic [57:0] d_diff_r;
  logic [27:0] d_n2_r;
  fdr_front_t  d_side_r;

  assign rhs     = {1'b0, c_n2_r, 30'b0};
  assign tir_nxt = (c_lhs_r >= rhs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_diff_r <= tir_nxt ? '0 : 58'(rhs - c_lhs_r);
      d_n2_r   <= c_n2_r;
      d_side_r <= '{tir: tir_nxt, ci: c_ci_r, n: c_n_r, d: c_d_r};
    end
  end

  // ---------------- squared transmitted cosine, q30 ----------------
  logic        ct2_vld;
  logic [30:0] ct2;
  fdr_front_t  ct2_side;

  fdr_div #(
    .NW (58),
    .DW (28),
    .QW (31),
    .SW ($bits(fdr_front_t))
  ) u_div_ct2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld_r),
    .in_num   (d_diff_r),
    .in_den   (d_n2_r),
    .in_side  (d_side_r),
    .out_vld  (ct2_vld),
    .out_quo  (ct2),
    .out_side (ct2_side)
  );

  // ---------------- transmitted cosine, q15 ----------------
  logic        ct_vld;
  logic [15:0] ct;
  fdr_front_t  ct_side;

  fdr_isqrt #(
    .IW (32),
    .SW ($bits(fdr_front_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (ct2_vld),
    .in_val   (32'(ct2)),
    .in_side  (ct2_side),
    .out_vld  (ct_vld),
    .out_root (ct),
    .out_side (ct_side)
  );

  // ---------------- stage e: cross products ----------------
  logic        e_vld_r;
  logic [29:0] e_nci_r;
  logic [29:0] e_dct_r;
  logic [29:0] e_dci_r;
  logic [29:0] e_nct_r;
  logic        e_tir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= ct_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_nci_r <= 30'(ct_side.n) * 30'(ct_side.ci);
      e_dct_r <= 30'(ct_side.d) * 30'(ct);
      e_dci_r <= 30'(ct_side.d) * 30'(ct_side.ci);
      e_nct_r <= 30'(ct_side.n) * 30'(ct);
      e_tir_r <= ct_side.tir;
    end
  end

  // ---------------- stage f: amplitude numerators and denominators ----------------
  logic [30:0] b1;
  logic [30:0] b2;
  logic        f_vld_r;
  logic [29:0] f_m1_r;
  logic [29:0] f_m2_r;
  logic [30:0] f_b1_r;
  logic [30:0] f_b2_r;
  logic        f_tir_r;
  logic        f_degen_r;

  assign b1 = 31'(e_nci_r) + 31'(e_dct_r);
  assign b2 = 31'(e_dci_r) + 31'(e_nct_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  // only magnitudes matter since both ratios are squared
  always_ff @(posedge clk) begin
    if (en) begin
      f_m1_r    <= (e_nci_r >= e_dct_r) ? (e_nci_r - e_dct_r) : (e_dct_r - e_nci_r);
      f_m2_r    <= (e_dci_r >= e_nct_r) ? (e_dci_r - e_nct_r) : (e_nct_r - e_dci_r);
      f_b1_r    <= b1;
      f_b2_r    <= b2;
      f_tir_r   <= e_tir_r;
      f_degen_r <= (b1 == '0) || (b2 == '0);
    end
  end

  // ---------------- s and p ratios, q30 ----------------
  logic        rs_vld;
  logic [30:0] rs;
  logic        rs_tir;
  logic        rp_vld;
  logic [30:0] rp;
  logic        rp_degen;

  fdr_div #(
    .NW (60),
    .DW (31),
    .QW (31),
    .SW (1)
  ) u_div_rs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld_r),
    .in_num   ({f_m1_r, 30'b0}),
    .in_den   (f_b1_r),
    .in_side  (f_tir_r),
    .out_vld  (rs_vld),
    .out_quo  (rs),
    .out_side (rs_tir)
  );

  fdr_div #(
    .NW (60),
    .DW (31),
    .QW (31),
    .SW (1)
  ) u_div_rp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld_r),
    .in_num   ({f_m2_r, 30'b0}),
    .in_den   (f_b2_r),
    .in_side  (f_degen_r),
    .out_vld  (rp_vld),
    .out_quo  (rp),
    .out_side (rp_degen)
  );

  // ---------------- stage g: squared ratios ----------------
  logic        g_vld_r;
  logic [61:0] g_sq1_r;
  logic [61:0] g_sq2_r;
  logic        g_tir_r;
  logic        g_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= rs_vld && rp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_sq1_r   <= 62'(rs) * 62'(rs);
      g_sq2_r   <= 62'(rp) * 62'(rp);
      g_tir_r   <= rs_tir;
      g_degen_r <= rp_degen;
    end
  end

  // ---- stage h: average, round half up, saturate, one for tir or degenerate ----
  logic [62:0] tot;
  logic [16:0] refl;
  logic        out_valid_r;
  logic [REFL_W-1:0] out_refl_r;
  logic        out_tir_r;

  // sum of squares over two in q60, back to q15 with the halving folded in
  assign tot  = 63'(g_sq1_r) + 63'(g_sq2_r) + (63'(1) << 45);
  assign refl = tot[62:46];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (g_tir_r || g_degen_r) begin
        out_refl_r <= ONE_Q15;
      end else if (refl > 17'(ONE_Q15)) begin
        out_refl_r <= ONE_Q15;
      end else begin
        out_refl_r <= refl[REFL_W-1:0];
      end
      out_tir_r <= g_tir_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reflectance    = out_refl_r;
  assign out_total_internal = out_tir_r;

  // ---------------- checks ----------------
  `include "fresnel_dielectric_reflectance_core_assert.svh"

  `FDR_ASSERT_NOW(a_refl_bound, out_valid, out_reflectance <= ONE_Q15, "reflectance above one")
  `FDR_ASSERT_NOW(a_tir_one, out_valid && out_total_internal, out_reflectance == ONE_Q15, "tir not one")
  `FDR_ASSERT_NOW(a_lanes_aligned, rs_vld || rp_vld, rs_vld && rp_vld, "ratio lanes out of step")
  `FDR_ASSERT_NEXT(a_hold_stall, in_stall, $stable(out_reflectance) && out_valid, "held result moved")

endmodule

@@ tb/sv/fresnel_dielectric_reflectance_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fresnel dielectric reflectance core testbench
// streams cosine and eta pairs through the core, predicts each reflectance
// in exact integer arithmetic and checks results in order with random gaps
// ----------------------------------------------------------------------------
class reflectance_board;
  logic [15:0] refl_q[$];
  logic        tir_q[$];
  int          mismatches;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // exact fraction eta = n/d, reciprocal for rays from inside
  function automatic void note_input(logic [15:0] cos_raw, logic [13:0] eta_raw);
    logic [63:0] e, ci, n, d, s2, lhs, rhs, ct, b1, b2, m1, m2, r1, r2, refl;
    logic        ray_inside;
    e = (eta_raw == 0) ? 64'd1 : 64'(eta_raw);
    ray_inside = cos_raw[15];
    ci = ray_inside ? (64'h10000 - 64'(cos_raw)) : 64'(cos_raw);
    n = ray_inside ? 64'd4096 : e;
    d = ray_inside ? e : 64'd4096;
    s2 = (64'd1 << 30) - ci * ci;
    lhs = s2 * d * d;
    rhs = n * n * (64'd1 << 30);
    if (lhs >= rhs) begin
      refl_q.push_back(16'd32768);
      tir_q.push_back(1'b1);
      return;
    end
    ct = int_sqrt((rhs - lhs) / (n * n));
    b1 = n * ci + d * ct;
    b2 = d * ci + n * ct;
    if (b1 == 0 || b2 == 0) begin
      refl_q.push_back(16'd32768);
      tir_q.push_back(1'b0);
      return;
    end
    m1 = (n * ci >= d * ct) ? n * ci - d * ct : d * ct - n * ci;
    m2 = (d * ci >= n * ct) ? d * ci - n * ct : n * ct - d * ci;
    r1 = (m1 << 30) / b1;
    r2 = (m2 << 30) / b2;
    refl = (r1 * r1 + r2 * r2 + (64'd1 << 45)) >> 46;
    if (refl > 32768) refl = 32768;
    refl_q.push_back(refl[15:0]);
    tir_q.push_back(1'b0);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic check_result(logic [15:0] refl, logic tir);
    logic [15:0] er;
    logic        et;
    if (refl_q.size() == 0) begin
      report("unexpected result", refl, 16'd0);
      return;
    end
    er = refl_q.pop_front();
    et = tir_q.pop_front();
    if (refl !== er) report("reflectance", refl, er);
    if (tir !== et) report("total_internal", 16'(tir), 16'(et));
  endtask
endclass

module fresnel_dielectric_reflectance_core_test;
  import fdr_pkg::*;

  localparam int LATENCY   = 86;
  localparam int MAX_CYCLE = 200000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic signed [15:0] in_cos_incident;
  logic [13:0]       in_refr_ratio;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       out_reflectance;
  logic              out_total_internal;

  reflectance_board board;
  int               cycle_count;
  bit               stim_done;

  fresnel_dielectric_reflectance_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cos_incident    (in_cos_incident),
    .in_refr_ratio      (in_refr_ratio),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_reflectance    (out_reflectance),
    .out_total_internal (out_total_internal)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one transfer: hold valid until the core takes it, gap first
  task automatic send_pair(logic [15:0] c, logic [13:0] e);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cos_incident <= c;
    in_refr_ratio   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(c, e);
  endtask

  // random eta, biased to the common range but reaching every bit
  function automatic logic [13:0] pick_eta();
    case ($urandom_range(0, 3))
      0: return 14'($urandom_range(3000, 6000));
      1: return 14'($urandom_range(1024, 16383));
      2: return 14'($urandom);
      default: return 14'($urandom_range(4000, 8200));
    endcase
  endfunction

  // result side: random stall per transfer, checked at the edge
  initial begin
    int hold;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = $urandom_range(0, 3);
      if (stim_done || ($urandom_range(0, 3) == 0)) hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(out_reflectance, out_total_internal);
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] dir_cos[12];
    logic [13:0] dir_eta[4];
    board = new();
    stim_done = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cos_incident <= '0;
    in_refr_ratio <= ETA_ONE;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: grazing, normal, both sides, extremes of eta, zero eta
    dir_cos = '{16'h7FFF, 16'h0000, 16'h8000, 16'h8001, 16'hFFFF, 16'h0001,
                16'h4000, 16'hC000, 16'h5A82, 16'hA57E, 16'h7000, 16'h9000};
    dir_eta = '{14'd1024, 14'd16383, 14'd4096, 14'd6144};
    foreach (dir_cos[i]) send_pair(dir_cos[i], dir_eta[i % 4]);
    send_pair(16'h4000, 14'd0);
    send_pair(16'hC000, 14'd0);
    send_pair(16'h8000, 14'd16383);
    send_pair(16'h0000, 14'd1024);
    send_pair(16'hE000, 14'd8192);
    send_pair(16'h2000, 14'd2048);

    // hold off until the pipeline has drained
    in_valid <= 1'b0;
    while (board.refl_q.size() != 0) @(posedge clk);

    repeat (400) send_pair(16'($urandom), pick_eta());
    in_valid <= 1'b0;
    stim_done = 1;

    while (board.refl_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (board.mismatches == 0 && board.refl_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+src
src/fdr_pkg.sv
src/fdr_div.sv
src/fdr_isqrt.sv
src/fresnel_dielectric_reflectance_core.sv
tb/sv/fresnel_dielectric_reflectance_core_test.sv
